>>> rtl/fcd_pkg.sv
// shared constants, types and helpers of the frame change detector
package fcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int DIM_W   = 11;
  localparam int WIN_W   = DIM_W + 1;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CNT_W   = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int CFG_IDX_W = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_WIN_LEFT     = 3'd2,
    REG_WIN_TOP      = 3'd3,
    REG_WIN_WIDTH    = 3'd4,
    REG_WIN_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_MARKER = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t          kind;
    logic [COL_W-1:0]   pos_x;
    logic [ROW_W-1:0]   pos_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CNT_W-1:0]   change_count;
    logic               last;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/fcd_pix_if.sv
// pixel input channel
interface fcd_pix_if;
  logic                         valid;
  logic                         ready;
  logic [fcd_pkg::CHAN_W-1:0]   red;
  logic [fcd_pkg::CHAN_W-1:0]   green;
  logic [fcd_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/fcd_res_if.sv
// result channel carrying change records and end of frame markers
interface fcd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fcd_pkg::COL_W-1:0]    pos_x;
  logic [fcd_pkg::ROW_W-1:0]    pos_y;
  logic [fcd_pkg::CHAN_W-1:0]   out_red;
  logic [fcd_pkg::CHAN_W-1:0]   out_green;
  logic [fcd_pkg::CHAN_W-1:0]   out_blue;
  logic [fcd_pkg::CNT_W-1:0]    change_count;
  logic                         last;

  modport source (output valid, output kind, output pos_x, output pos_y, output out_red,
                  output out_green, output out_blue, output change_count, output last,
                  input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y, input out_red,
                  input out_green, input out_blue, input change_count, input last,
                  output ready);
endinterface

>>> rtl/frame_change_detector.sv
// frame change detector top level: pixel store, raster counters and result queue
// stage 1 compares each accepted pixel and queues its results; throughput: one pixel per
// cycle while in_pix.ready is high, set by the read-modify-write of the pixel store; one
// result item per cycle while out_res.ready is high; a frame end adds a marker item to that
// pixel; reset: synchronous; after reset a clearing pass writes black to all 1,048,576 store
// entries, one per cycle, with in_pix.ready low; configuration writes are taken meanwhile
module frame_change_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fcd_pkg::DIM_W-1:0]      cfg_wdata,
  fcd_pix_if.sink                        in_pix,
  fcd_res_if.source                      out_res
);

  // configuration registers
  logic [fcd_pkg::DIM_W-1:0] frame_width_r;
  logic [fcd_pkg::DIM_W-1:0] frame_height_r;
  logic [fcd_pkg::COL_W-1:0] win_left_r;
  logic [fcd_pkg::ROW_W-1:0] win_top_r;
  logic [fcd_pkg::DIM_W-1:0] win_width_r;
  logic [fcd_pkg::DIM_W-1:0] win_height_r;

  // raster counters
  logic [fcd_pkg::COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [fcd_pkg::ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [fcd_pkg::CNT_W-1:0] frame_changes_r, frame_changes_nxt;

  // clearing pass
  logic                        clr_busy_r;
  logic [fcd_pkg::ADDR_W-1:0]  clr_addr_r;

  // stage 0
  logic                        accept;
  logic [fcd_pkg::DIM_W-1:0]   fw, fh, col_inc, row_inc;
  logic [fcd_pkg::COL_W-1:0]   x0;
  logic [fcd_pkg::ROW_W-1:0]   y0;
  logic                        wrap_col, eof0;
  logic [fcd_pkg::ADDR_W-1:0]  addr0;

  // stage 1
  logic                        s1_vld_r;
  logic [fcd_pkg::COL_W-1:0]   s1_x_r;
  logic [fcd_pkg::ROW_W-1:0]   s1_y_r;
  logic [fcd_pkg::PIX_W-1:0]   s1_pix_r;
  logic                        s1_eof_r;
  logic [fcd_pkg::ADDR_W-1:0]  s1_addr;
  logic [fcd_pkg::PIX_W-1:0]   old_pix;
  logic                        changed, in_win, rec, marker;
  logic [fcd_pkg::WIN_W-1:0]   x_e, y_e, left_e, top_e, right_e, bottom_e;
  logic [fcd_pkg::CNT_W-1:0]   cnt_after;

  // last store access, for a read that overlaps the write of the previous pixel
  logic                        fwd_vld_r;
  logic [fcd_pkg::ADDR_W-1:0]  fwd_addr_r;
  logic [fcd_pkg::PIX_W-1:0]   fwd_data_r;

  // pixel store
  logic [fcd_pkg::PIX_W-1:0]   pix_mem [fcd_pkg::MEM_DEPTH];
  logic [fcd_pkg::PIX_W-1:0]   rd_data_r;
  logic                        mem_we;
  logic [fcd_pkg::ADDR_W-1:0]  mem_wa;
  logic [fcd_pkg::PIX_W-1:0]   mem_wd;

  // result queue
  fcd_pkg::result_t            fifo_q [fcd_pkg::FIFO_DEPTH];
  logic [fcd_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r, mrk_ptr;
  logic [fcd_pkg::OCC_W-1:0]   occ_r;
  logic [fcd_pkg::OCC_W-1:0]   push_n;
  logic                        pop;
  fcd_pkg::result_t            rec_res, mrk_res, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= fcd_pkg::DIM_W'(fcd_pkg::MAX_WIDTH);
      frame_height_r <= fcd_pkg::DIM_W'(fcd_pkg::MAX_HEIGHT);
      win_left_r     <= '0;
      win_top_r      <= '0;
      win_width_r    <= fcd_pkg::DIM_W'(fcd_pkg::MAX_WIDTH);
      win_height_r   <= fcd_pkg::DIM_W'(fcd_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      case (fcd_pkg::cfg_reg_t'(cfg_idx))
        fcd_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        fcd_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        fcd_pkg::REG_WIN_LEFT:     win_left_r     <= cfg_wdata[fcd_pkg::COL_W-1:0];
        fcd_pkg::REG_WIN_TOP:      win_top_r      <= cfg_wdata[fcd_pkg::ROW_W-1:0];
        fcd_pkg::REG_WIN_WIDTH:    win_width_r    <= cfg_wdata;
        fcd_pkg::REG_WIN_HEIGHT:   win_height_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: position of the incoming pixel and counter advance
  assign accept = in_pix.valid && in_pix.ready;
  assign in_pix.ready = !clr_busy_r &&
                        (occ_r <= fcd_pkg::OCC_W'(fcd_pkg::FIFO_DEPTH - 4));

  always_comb begin
    fw = fcd_pkg::clamp_dim(frame_width_r, fcd_pkg::DIM_W'(fcd_pkg::MAX_WIDTH));
    fh = fcd_pkg::clamp_dim(frame_height_r, fcd_pkg::DIM_W'(fcd_pkg::MAX_HEIGHT));
    x0 = (fcd_pkg::DIM_W'(col_pos_r) >= fw) ? '0 : col_pos_r;
    y0 = (fcd_pkg::DIM_W'(row_pos_r) >= fh) ? '0 : row_pos_r;
    col_inc = fcd_pkg::DIM_W'(x0) + fcd_pkg::DIM_W'(1);
    row_inc = fcd_pkg::DIM_W'(y0) + fcd_pkg::DIM_W'(1);
    wrap_col = (col_inc >= fw);
    eof0 = wrap_col && (row_inc >= fh);
    col_pos_nxt = wrap_col ? '0 : col_inc[fcd_pkg::COL_W-1:0];
    if (!wrap_col) begin
      row_pos_nxt = y0;
    end else if (eof0) begin
      row_pos_nxt = '0;
    end else begin
      row_pos_nxt = row_inc[fcd_pkg::ROW_W-1:0];
    end
    addr0 = {y0, x0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_vld_r   <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      fwd_vld_r  <= 1'b0;
    end else begin
      s1_vld_r  <= accept;
      fwd_vld_r <= s1_vld_r;
      if (accept) begin
        col_pos_r <= col_pos_nxt;
        row_pos_r <= row_pos_nxt;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + fcd_pkg::ADDR_W'(1);
        if (clr_addr_r == {fcd_pkg::ADDR_W{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r   <= x0;
      s1_y_r   <= y0;
      s1_pix_r <= {in_pix.red, in_pix.green, in_pix.blue};
      s1_eof_r <= eof0;
    end
    fwd_addr_r <= s1_addr;
    fwd_data_r <= s1_pix_r;
  end

  // pixel store, read-before-write
  assign mem_we = clr_busy_r || (s1_vld_r && changed);
  assign mem_wa = clr_busy_r ? clr_addr_r : s1_addr;
  assign mem_wd = clr_busy_r ? '0 : s1_pix_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_r <= pix_mem[addr0];
    end
  end

  // stage 1: compare, window test and change count
  always_comb begin
    s1_addr  = {s1_y_r, s1_x_r};
    old_pix  = (fwd_vld_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : rd_data_r;
    changed  = (old_pix != s1_pix_r);
    x_e      = fcd_pkg::WIN_W'(s1_x_r);
    y_e      = fcd_pkg::WIN_W'(s1_y_r);
    left_e   = fcd_pkg::WIN_W'(win_left_r);
    top_e    = fcd_pkg::WIN_W'(win_top_r);
    right_e  = left_e + fcd_pkg::WIN_W'(win_width_r);
    bottom_e = top_e + fcd_pkg::WIN_W'(win_height_r);
    in_win   = (x_e >= left_e) && (x_e < right_e) && (y_e >= top_e) && (y_e < bottom_e);
    rec      = s1_vld_r && changed && in_win;
    marker   = s1_vld_r && s1_eof_r;
    cnt_after = (rec && (frame_changes_r != fcd_pkg::CNT_MAX))
                ? frame_changes_r + fcd_pkg::CNT_W'(1) : frame_changes_r;
    frame_changes_nxt = marker ? '0 : cnt_after;

    rec_res.kind         = fcd_pkg::KIND_RECORD;
    rec_res.pos_x        = s1_x_r;
    rec_res.pos_y        = s1_y_r;
    rec_res.red          = s1_pix_r[fcd_pkg::PIX_W-1 -: fcd_pkg::CHAN_W];
    rec_res.green        = s1_pix_r[2*fcd_pkg::CHAN_W-1 -: fcd_pkg::CHAN_W];
    rec_res.blue         = s1_pix_r[fcd_pkg::CHAN_W-1:0];
    rec_res.change_count = '0;
    rec_res.last         = !s1_eof_r;

    mrk_res.kind         = fcd_pkg::KIND_MARKER;
    mrk_res.pos_x        = '0;
    mrk_res.pos_y        = '0;
    mrk_res.red          = '0;
    mrk_res.green        = '0;
    mrk_res.blue         = '0;
    mrk_res.change_count = cnt_after;
    mrk_res.last         = 1'b1;

    mrk_ptr = rec ? wr_ptr_r + fcd_pkg::FIFO_AW'(1) : wr_ptr_r;
    push_n  = fcd_pkg::OCC_W'(rec) + fcd_pkg::OCC_W'(marker);
    pop     = out_res.valid && out_res.ready;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_changes_r <= '0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      occ_r           <= '0;
    end else begin
      if (s1_vld_r) begin
        frame_changes_r <= frame_changes_nxt;
      end
      wr_ptr_r <= wr_ptr_r + push_n[fcd_pkg::FIFO_AW-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + fcd_pkg::FIFO_AW'(1);
      end
      occ_r <= occ_r + push_n - fcd_pkg::OCC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rec) begin
      fifo_q[wr_ptr_r] <= rec_res;
    end
    if (marker) begin
      fifo_q[mrk_ptr] <= mrk_res;
    end
  end

  assign head = fifo_q[rd_ptr_r];

  assign out_res.valid        = (occ_r != '0);
  assign out_res.kind         = head.kind;
  assign out_res.pos_x        = head.pos_x;
  assign out_res.pos_y        = head.pos_y;
  assign out_res.out_red      = head.red;
  assign out_res.out_green    = head.green;
  assign out_res.out_blue     = head.blue;
  assign out_res.change_count = head.change_count;
  assign out_res.last         = head.last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= fcd_pkg::OCC_W'(fcd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_pix.ready)
    else $error("item taken during clearing pass");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_vld_r)
    else $error("accepted item lost before compare stage");

  a_marker_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    marker |=> (frame_changes_r == '0))
    else $error("change count not cleared after frame end");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the frame change detector: directed and random pixel streams
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned TALL_ITEMS   = 128;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0] cfg_wdata;

  fcd_pix_if pix_ch ();
  fcd_res_if res_ch ();

  frame_change_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_ch),
    .out_res   (res_ch)
  );

  // shadow of the block's state and registers
  logic [PIX_W-1:0] frame_shadow [int unsigned];
  int unsigned col_now;
  int unsigned row_now;
  int unsigned changes_now;
  logic [DIM_W-1:0] fw_reg;
  logic [DIM_W-1:0] fh_reg;
  logic [COL_W-1:0] wl_reg;
  logic [ROW_W-1:0] wt_reg;
  logic [DIM_W-1:0] ww_reg;
  logic [DIM_W-1:0] wh_reg;

  result_t results_due [$];
  int unsigned pixels_sent;
  bit failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned dim_eff(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void wrap_position();
    if (col_now >= dim_eff(fw_reg, MAX_WIDTH)) col_now = 0;
    if (row_now >= dim_eff(fh_reg, MAX_HEIGHT)) row_now = 0;
  endfunction

  function automatic logic [PIX_W-1:0] stored_pixel();
    int unsigned addr;
    wrap_position();
    addr = row_now * MAX_WIDTH + col_now;
    return frame_shadow.exists(addr) ? frame_shadow[addr] : '0;
  endfunction

  function automatic void predict_pixel(logic [PIX_W-1:0] pix);
    int unsigned x;
    int unsigned y;
    logic [PIX_W-1:0] old;
    result_t rec;
    result_t mark;
    bit has_rec;
    bit has_mark;
    old = stored_pixel();
    x = col_now;
    y = row_now;
    has_rec = 1'b0;
    has_mark = 1'b0;
    rec = '0;
    mark = '0;
    if (old != pix) begin
      frame_shadow[y * MAX_WIDTH + x] = pix;
      if (ww_reg != '0 && wh_reg != '0 && x >= wl_reg && x < wl_reg + ww_reg &&
          y >= wt_reg && y < wt_reg + wh_reg) begin
        has_rec = 1'b1;
        rec.kind = KIND_RECORD;
        rec.pos_x = COL_W'(x);
        rec.pos_y = ROW_W'(y);
        rec.red = pix[23:16];
        rec.green = pix[15:8];
        rec.blue = pix[7:0];
        if (changes_now < CNT_MAX) changes_now++;
      end
    end
    col_now = x + 1;
    if (col_now >= dim_eff(fw_reg, MAX_WIDTH)) begin
      col_now = 0;
      row_now = y + 1;
      if (row_now >= dim_eff(fh_reg, MAX_HEIGHT)) begin
        row_now = 0;
        has_mark = 1'b1;
        mark.kind = KIND_MARKER;
        mark.change_count = CNT_W'(changes_now);
        mark.last = 1'b1;
        changes_now = 0;
      end
    end
    rec.last = !has_mark;
    if (has_rec) results_due.push_back(rec);
    if (has_mark) results_due.push_back(mark);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_W-1:0] choose_pixel();
    logic [PIX_W-1:0] old;
    int unsigned r;
    old = stored_pixel();
    r = $urandom_range(0, 99);
    if (r < 45) return old;
    if (r < 60) return old ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
    return PIX_W'($urandom());
  endfunction

  function automatic logic [DIM_W-1:0] rand_frame_dim(int unsigned hi);
    return ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [DIM_W-1:0] rand_win_start(int unsigned hi);
    return ($urandom_range(0, 4) != 0) ? DIM_W'($urandom_range(0, hi))
                                       : DIM_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [DIM_W-1:0] rand_win_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 85) return DIM_W'($urandom_range(1, 14));
    return DIM_W'($urandom_range(15, 2047));
  endfunction

  // every task starts and ends at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    pix_ch.valid <= 1'b1;
    pix_ch.red <= pix[23:16];
    pix_ch.green <= pix[15:8];
    pix_ch.blue <= pix[7:0];
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    predict_pixel(pix);
    pixels_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_WIDTH: fw_reg = val;
      REG_FRAME_HEIGHT: fh_reg = val;
      REG_WIN_LEFT: wl_reg = val[COL_W-1:0];
      REG_WIN_TOP: wt_reg = val[ROW_W-1:0];
      REG_WIN_WIDTH: ww_reg = val;
      REG_WIN_HEIGHT: wh_reg = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh,
                                input logic [DIM_W-1:0] wl, input logic [DIM_W-1:0] wt,
                                input logic [DIM_W-1:0] ww, input logic [DIM_W-1:0] wh);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_WIN_LEFT, wl);
    write_reg(REG_WIN_TOP, wt);
    write_reg(REG_WIN_WIDTH, ww);
    write_reg(REG_WIN_HEIGHT, wh);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 149) == 0) settle();
      send_pixel(choose_pixel());
    end
  endtask

  task automatic send_tagged_frame(input int unsigned tag);
    for (int unsigned i = 0; i < 4; i++) begin
      send_pixel({8'(tag * 37), 8'(i * 85), ~8'(tag)});
    end
    settle();
  endtask

  task automatic test_reset_defaults();
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'hff0000);
    send_pixel(24'h00ff00);
    send_pixel(24'h0000ff);
    send_pixel(24'h5a5a5a);
    settle();
  endtask

  task automatic test_size_change();
    // column counter is past the new width and must wrap
    write_reg(REG_FRAME_WIDTH, 11'd2);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h123456);
    send_pixel(24'h00ff00);
    settle();
  endtask

  task automatic test_window_limits();
    write_reg(REG_WIN_LEFT, 11'd1);
    write_reg(REG_WIN_TOP, 11'd1);
    write_reg(REG_WIN_WIDTH, 11'd1);
    write_reg(REG_WIN_HEIGHT, 11'd1);
    send_tagged_frame(1);
    write_reg(REG_WIN_LEFT, 11'd0);
    write_reg(REG_WIN_TOP, 11'd0);
    write_reg(REG_WIN_WIDTH, 11'd0);
    write_reg(REG_WIN_HEIGHT, 11'd1024);
    send_tagged_frame(2);
    write_reg(REG_WIN_WIDTH, 11'd1024);
    write_reg(REG_WIN_HEIGHT, 11'd0);
    send_tagged_frame(3);
    write_reg(REG_WIN_HEIGHT, 11'd1024);
    write_reg(REG_WIN_LEFT, 11'h7ff);
    write_reg(REG_WIN_TOP, 11'd1023);
    send_tagged_frame(4);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned batch;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      write_all_regs(rand_frame_dim(12), rand_frame_dim(6), rand_win_start(12),
                     rand_win_start(8), rand_win_size(), rand_win_size());
      batch = dim_eff(fw_reg, MAX_WIDTH) * dim_eff(fh_reg, MAX_HEIGHT) *
              $urandom_range(1, 3) + $urandom_range(0, 2);
      send_random_pixels(batch);
      settle();
    end
  endtask

  task automatic test_wide_row();
    write_all_regs(11'd2047, 11'd1, 11'd1000, 11'd0, 11'd1024, 11'd1024);
    send_random_pixels(MAX_WIDTH);
    settle();
  endtask

  task automatic test_tall_column();
    write_all_regs(11'd0, 11'd2047, 11'd0, 11'd100, 11'd1, 11'd2047);
    send_random_pixels(TALL_ITEMS);
    settle();
  endtask

  initial begin : drive_result_ready
    int unsigned run;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      res_ch.ready <= 1'b1;
      repeat (run) @(negedge clk);
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
      res_ch.ready <= 1'b0;
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.kind = res_kind_t'(res_ch.kind);
      got.pos_x = res_ch.pos_x;
      got.pos_y = res_ch.pos_y;
      got.red = res_ch.out_red;
      got.green = res_ch.out_green;
      got.blue = res_ch.out_blue;
      got.change_count = res_ch.change_count;
      got.last = res_ch.last;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected item %p", $time, got);
        failed = 1'b1;
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind || got.pos_x !== want.pos_x ||
            got.pos_y !== want.pos_y || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.change_count !== want.change_count || got.last !== want.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    col_now = 0;
    row_now = 0;
    changes_now = 0;
    fw_reg = 11'd1024;
    fh_reg = 11'd1024;
    wl_reg = '0;
    wt_reg = '0;
    ww_reg = 11'd1024;
    wh_reg = 11'd1024;
    pixels_sent = 0;
    failed = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_size_change();
    test_window_limits();
    test_random_frames();
    test_wide_row();
    test_tall_column();

    for (int i = 0; i < 20000 && results_due.size() != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, results_due.size());
    end
    if (!failed && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
